// ----- hw/rtl/idt_pkg.sv -----
`default_nettype none

package idt_pkg;

   localparam int unsigned TimeWidth     = 32;
   localparam int unsigned IntervalWidth = 31;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_INTERVAL_MS = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ENDLESS     = 2'd1;

   typedef enum logic [2:0] {
      MODE_POLL   = 3'd0,
      MODE_START  = 3'd1,
      MODE_STOP   = 3'd2,
      MODE_PAUSE  = 3'd3,
      MODE_EXTEND = 3'd4,
      MODE_SET    = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      RUN_STOPPED  = 2'd0,
      RUN_RUNNING  = 2'd1,
      RUN_PAUSED   = 2'd2,
      RUN_FINISHED = 2'd3
   } run_state_type;

   typedef struct packed {
      logic                 start;
      logic [TimeWidth-1:0] dividend;
      logic [TimeWidth-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic                 done;
      logic [TimeWidth-1:0] remainder;
   } rem_rsp_type;

   typedef struct packed {
      logic          valid;
      run_state_type status;
      logic          interval_event;
      logic          finish_event;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/idt_rem_unit.sv -----
`default_nettype none

module idt_rem_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  idt_pkg::rem_req_type rem_req,
   output idt_pkg::rem_rsp_type rem_rsp
);

   localparam int unsigned W  = idt_pkg::TimeWidth;
   localparam int unsigned CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W-1:0]  dividend_ff, dividend_in;
   logic [W-1:0]  divisor_ff, divisor_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   assign trial = {rem_ff, dividend_ff[W-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (rem_req.start) begin
         busy_in     = 1'b1;
         count_in    = '0;
         dividend_in = rem_req.dividend;
         divisor_in  = rem_req.divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = diff[W-1:0];
         end else begin
            rem_in = trial[W-1:0];
         end
         dividend_in = {dividend_ff[W-2:0], 1'b0};
         count_in    = count_ff + CW'(1);
         if (count_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff    <= count_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign rem_rsp.done      = done_ff;
   assign rem_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/idt_ctrl.sv -----
`default_nettype none

module idt_ctrl (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_valid,
   output logic                                       req_ready,
   input  idt_pkg::mode_type                          mode,
   input  wire [idt_pkg::TimeWidth-1:0]               now_ms,
   input  wire [idt_pkg::TimeWidth-1:0]               amount_ms,
   input  wire [idt_pkg::IntervalWidth-1:0]           interval_ms,
   input  wire                                        endless,
   input  wire                                        out_free,
   output idt_pkg::rem_req_type                       rem_req,
   input  idt_pkg::rem_rsp_type                       rem_rsp,
   output idt_pkg::result_type                        result,
   output idt_pkg::run_state_type                     run_state
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_DONE = 3'b100
   } fsm_type;

   fsm_type                         fsm_ff, fsm_in;
   idt_pkg::run_state_type          run_ff, run_in;
   logic [idt_pkg::TimeWidth-1:0]   stamp_ff, stamp_in;
   logic [idt_pkg::TimeWidth-1:0]   deadline_ff, deadline_in;
   logic                            phase_ff, phase_in;
   logic                            iev_ff, iev_in;
   logic                            fev_ff, fev_in;
   logic [idt_pkg::TimeWidth-1:0]   elapsed;

   assign elapsed = now_ms - stamp_ff;

   always_comb begin
      fsm_in           = fsm_ff;
      run_in           = run_ff;
      stamp_in         = stamp_ff;
      deadline_in      = deadline_ff;
      phase_in         = phase_ff;
      iev_in           = iev_ff;
      fev_in           = fev_ff;
      rem_req.start    = 1'b0;
      rem_req.dividend = elapsed;
      rem_req.divisor  = {interval_ms, 1'b0};
      unique case (fsm_ff)
         S_IDLE: begin
            if (req_valid) begin
               iev_in = 1'b0;
               fev_in = 1'b0;
               fsm_in = S_DONE;
               unique case (mode)
                  idt_pkg::MODE_POLL: begin
                     if (run_ff == idt_pkg::RUN_RUNNING) begin
                        if (!endless && (elapsed > deadline_ff)) begin
                           run_in = idt_pkg::RUN_FINISHED;
                           fev_in = 1'b1;
                        end else if (interval_ms != '0) begin
                           rem_req.start = 1'b1;
                           fsm_in        = S_CALC;
                        end
                     end
                  end
                  idt_pkg::MODE_START: begin
                     if (run_ff == idt_pkg::RUN_STOPPED) begin
                        stamp_in = now_ms;
                     end
                     run_in = idt_pkg::RUN_RUNNING;
                  end
                  idt_pkg::MODE_STOP: begin
                     run_in = idt_pkg::RUN_STOPPED;
                  end
                  idt_pkg::MODE_PAUSE: begin
                     run_in = idt_pkg::RUN_PAUSED;
                  end
                  idt_pkg::MODE_EXTEND: begin
                     if (run_ff == idt_pkg::RUN_RUNNING) begin
                        deadline_in = deadline_ff + amount_ms;
                     end else begin
                        deadline_in = amount_ms;
                        if (run_ff == idt_pkg::RUN_STOPPED) begin
                           stamp_in = now_ms;
                        end
                        run_in = idt_pkg::RUN_RUNNING;
                     end
                  end
                  idt_pkg::MODE_SET: begin
                     deadline_in = amount_ms;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CALC: begin
            if (rem_rsp.done) begin
               if (rem_rsp.remainder > {1'b0, interval_ms}) begin
                  if (!phase_ff) begin
                     iev_in   = 1'b1;
                     phase_in = 1'b1;
                  end
               end else if (phase_ff) begin
                  iev_in   = 1'b1;
                  phase_in = 1'b0;
               end
               fsm_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               fsm_in = S_IDLE;
            end
         end
         default: begin
            fsm_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff      <= S_IDLE;
         run_ff      <= idt_pkg::RUN_STOPPED;
         stamp_ff    <= '0;
         deadline_ff <= '0;
         phase_ff    <= 1'b0;
         iev_ff      <= 1'b0;
         fev_ff      <= 1'b0;
      end else begin
         fsm_ff      <= fsm_in;
         run_ff      <= run_in;
         stamp_ff    <= stamp_in;
         deadline_ff <= deadline_in;
         phase_ff    <= phase_in;
         iev_ff      <= iev_in;
         fev_ff      <= fev_in;
      end
   end

   assign req_ready             = (fsm_ff == S_IDLE);
   assign result.valid          = (fsm_ff == S_DONE);
   assign result.status         = run_ff;
   assign result.interval_event = iev_ff;
   assign result.finish_event   = fev_ff;
   assign run_state             = run_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/interval_and_deadline_timer_core.sv -----
`default_nettype none

// Command-driven interval and deadline timer. Each request transfer carries one command
// (req_tuser) with the current millisecond time and an amount, and yields exactly one
// response transfer holding the timer status and the interval and finish event flags.
// Most commands go from idle straight to done; a poll of a running timer that does not
// finish and has a nonzero interval waits in between on the radix-2 remainder unit that
// reduces the elapsed time modulo twice the interval one bit per cycle. A new request is
// taken once the previous result has moved into the output register, even while that
// result still waits for rsp_tready. Configuration writes on the csr port take effect at
// once; a write of the endless flag while the timer is running or paused is ignored.

module interval_and_deadline_timer_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [63:0]                          req_tdata,   // now_ms, amount_ms
   input  wire [2:0]                           req_tuser,   // mode
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [7:0]                          rsp_tdata,   // status, interval_event,
                                                            // finish_event, zero fill
   input  wire                                 csr_we,
   input  wire [idt_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire [idt_pkg::IntervalWidth-1:0]    csr_wdata
);

   logic [idt_pkg::IntervalWidth-1:0] interval_ff, interval_in;
   logic                              endless_ff, endless_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [7:0]                        rsp_data_ff, rsp_data_in;
   logic                              out_free;
   idt_pkg::rem_req_type              rem_req;
   idt_pkg::rem_rsp_type              rem_rsp;
   idt_pkg::result_type               result;
   idt_pkg::run_state_type            run_state;

   assign out_free = !rsp_valid_ff || rsp_tready;

   idt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .mode        (idt_pkg::mode_type'(req_tuser)),
      .now_ms      (req_tdata[31:0]),
      .amount_ms   (req_tdata[63:32]),
      .interval_ms (interval_ff),
      .endless     (endless_ff),
      .out_free    (out_free),
      .rem_req     (rem_req),
      .rem_rsp     (rem_rsp),
      .result      (result),
      .run_state   (run_state)
   );

   idt_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   always_comb begin
      interval_in = interval_ff;
      endless_in  = endless_ff;
      if (csr_we) begin
         if (csr_index == idt_pkg::CSR_INTERVAL_MS) begin
            interval_in = csr_wdata;
         end else if (csr_index == idt_pkg::CSR_ENDLESS) begin
            if (run_state != idt_pkg::RUN_RUNNING && run_state != idt_pkg::RUN_PAUSED) begin
               endless_in = csr_wdata[0];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            rsp_data_in = {4'b0000, result.finish_event, result.interval_event,
                           result.status};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= '0;
         endless_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         interval_ff  <= interval_in;
         endless_ff   <= endless_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
